/* hdl/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg
// Types and constants shared by the shelf rectangle packer modules.
// ----------------------------------------------------------------------------
package srp_pkg;

  // Field widths fixed by the interface.
  localparam int DIM_W   = 15;
  localparam int AREA_W  = 29;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

  // Canvas size after reset.
  localparam logic [DIM_W-1:0] CANVAS_RESET = 15'd4096;

  // Largest value the area accumulator can hold.
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [AREA_W-1:0] area_t;

  // One shelf table entry.
  typedef struct packed {
    dim_t height;
    dim_t top;
    dim_t fill;
  } shelf_t;

  // Result of the shared add and compare unit.
  typedef struct packed {
    logic           fits;
    logic [DIM_W:0] sum;
  } fit_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NEW,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

/* hdl/srp_if.sv */
// ----------------------------------------------------------------------------
// srp_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface srp_in_if;
  logic                valid;
  logic                ready;
  srp_pkg::dim_t       rect_width;
  srp_pkg::dim_t       rect_height;

  modport source (output valid, output rect_width, output rect_height, input ready);
  modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

interface srp_out_if;
  logic                valid;
  logic                ready;
  logic                placed;
  srp_pkg::dim_t       place_left;
  srp_pkg::dim_t       place_top;
  srp_pkg::dim_t       place_width;
  srp_pkg::dim_t       place_height;
  srp_pkg::area_t      area_used;

  modport source (output valid, output placed, output place_left, output place_top,
                  output place_width, output place_height, output area_used,
                  input ready);
  modport sink   (input valid, input placed, input place_left, input place_top,
                  input place_width, input place_height, input area_used,
                  output ready);
endinterface

interface srp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [srp_pkg::CFG_IDX_W-1:0]     reg_index;
  srp_pkg::dim_t                     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* hdl/srp_ram.sv */
// ----------------------------------------------------------------------------
// srp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module srp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/srp_fit.sv */
// ----------------------------------------------------------------------------
// srp_fit
// Shared add and compare unit: checks whether a base plus an extent stays
// within a limit, either inclusive (shelf width) or strict (canvas height).
// ----------------------------------------------------------------------------
module srp_fit (
  input  srp_pkg::dim_t base,
  input  srp_pkg::dim_t extent,
  input  srp_pkg::dim_t limit,
  input  logic          strict,
  output srp_pkg::fit_t res
);
  import srp_pkg::*;

  logic [DIM_W:0] sum;

  // One wide add and one compare.
  always_comb begin
    sum      = {1'b0, base} + {1'b0, extent};
    res.sum  = sum;
    res.fits = strict ? (sum < {1'b0, limit}) : (sum <= {1'b0, limit});
  end

endmodule

/* hdl/shelf_rectangle_packer.sv */
// ----------------------------------------------------------------------------
// shelf_rectangle_packer
// First-fit shelf packer: scans the shelf table one entry per cycle through
// a shared add/compare unit, opens a new shelf when none fits, and keeps a
// saturating running sum of the placed area.
// Sequence: an accepted request scans the shelves, opens a new shelf when
//   none fits, then multiplies and accumulates the area; a failure goes
//   straight to the result. A new request waits until the result is taken;
//   the scan of up to MAX_SHELVES entries uses the single RAM read port.
// Reset: synchronous, clears the shelf count, next top, area and sets the
//   canvas to 4096 x 4096; the shelf table RAM itself is not cleared.
// ----------------------------------------------------------------------------
module shelf_rectangle_packer #(
  parameter int MAX_SHELVES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  srp_in_if.sink    in_port,
  srp_out_if.source out_port,
  srp_cfg_if.sink   cfg_port
);
  import srp_pkg::*;

  localparam int IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CNT_W = $clog2(MAX_SHELVES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SHELVES);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  dim_t               ntop_r, ntop_nxt;
  area_t              area_r, area_nxt;
  dim_t               cw_r, ch_r;
  dim_t               w_r, h_r;
  dim_t               left_r, left_nxt;
  dim_t               top_r, top_nxt;
  logic               ok_r, ok_nxt;
  logic [2*DIM_W-1:0] prod_r;
  logic [AREA_W+1:0]  total;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  shelf_t             ram_wdata;
  shelf_t             ram_q;

  dim_t               fit_base, fit_extent, fit_limit;
  logic               fit_strict;
  fit_t               fit_res;
  logic               hit;
  logic               last;

  // Shelf table.
  srp_ram #(
    .WIDTH ($bits(shelf_t)),
    .DEPTH (MAX_SHELVES),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_q)
  );

  // The add/compare unit checks shelf width while scanning and canvas height
  // when a new shelf is considered.
  always_comb begin
    if (state_r == ST_SCAN) begin
      fit_base   = ram_q.fill;
      fit_extent = w_r;
      fit_limit  = cw_r;
      fit_strict = 1'b0;
    end else begin
      fit_base   = ntop_r;
      fit_extent = h_r;
      fit_limit  = ch_r;
      fit_strict = 1'b1;
    end
  end

  srp_fit u_fit (
    .base   (fit_base),
    .extent (fit_extent),
    .limit  (fit_limit),
    .strict (fit_strict),
    .res    (fit_res)
  );

  assign hit  = (ram_q.height == h_r) && fit_res.fits;
  assign last = ({{(CNT_W-IDX_W){1'b0}}, idx_r} + CNT_W'(1)) == cnt_r;

  // Saturating area sum.
  assign total = {2'b00, area_r} + {1'b0, prod_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_port.valid) begin
          state_nxt = (cnt_r != '0) ? ST_SCAN : ST_NEW;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_MUL;
        end else if (last) begin
          state_nxt = ST_NEW;
        end
      end
      ST_NEW: begin
        if (cnt_r < CNT_MAX && fit_res.fits) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_port.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    ntop_nxt  = ntop_r;
    area_nxt  = area_r;
    left_nxt  = left_r;
    top_nxt   = top_r;
    ok_nxt    = ok_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_q;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
      end
      ST_SCAN: begin
        if (hit) begin
          // Place at the shelf's old used width and grow it.
          ram_we         = 1'b1;
          ram_wdata.fill = fit_res.sum[DIM_W-1:0];
          left_nxt       = ram_q.fill;
          top_nxt        = ram_q.top;
          ok_nxt         = 1'b1;
        end else if (!last) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_NEW: begin
        if (cnt_r < CNT_MAX && fit_res.fits) begin
          // Open a new shelf at the next free top.
          ram_we           = 1'b1;
          ram_waddr        = cnt_r[IDX_W-1:0];
          ram_wdata.height = h_r;
          ram_wdata.top    = ntop_r;
          ram_wdata.fill   = w_r;
          cnt_nxt          = cnt_r + CNT_W'(1);
          ntop_nxt         = fit_res.sum[DIM_W-1:0];
          left_nxt         = '0;
          top_nxt          = ntop_r;
          ok_nxt           = 1'b1;
        end else begin
          left_nxt = '0;
          top_nxt  = '0;
          ok_nxt   = 1'b0;
        end
      end
      ST_ACC: begin
        area_nxt = (total > {2'b00, AREA_MAX}) ? AREA_MAX : total[AREA_W-1:0];
      end
      ST_MUL, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ntop_r  <= '0;
      area_r  <= '0;
      cw_r    <= CANVAS_RESET;
      ch_r    <= CANVAS_RESET;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ntop_r  <= ntop_nxt;
      area_r  <= area_nxt;
      ok_r    <= ok_nxt;
      if (cfg_port.valid) begin
        unique case (cfg_port.reg_index)
          CFG_CANVAS_WIDTH:  cw_r <= cfg_port.wdata;
          CFG_CANVAS_HEIGHT: ch_r <= cfg_port.wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    top_r  <= top_nxt;
    if (state_r == ST_IDLE && in_port.valid) begin
      w_r <= in_port.rect_width;
      h_r <= in_port.rect_height;
    end
    if (state_r == ST_MUL) begin
      prod_r <= (2*DIM_W)'(w_r) * (2*DIM_W)'(h_r);
    end
  end

  // Handshakes and result word.
  assign in_port.ready         = (state_r == ST_IDLE);
  assign cfg_port.ready        = 1'b1;
  assign out_port.valid        = (state_r == ST_DONE);
  assign out_port.placed       = ok_r;
  assign out_port.place_left   = left_r;
  assign out_port.place_top    = top_r;
  assign out_port.place_width  = ok_r ? w_r : '0;
  assign out_port.place_height = ok_r ? h_r : '0;
  assign out_port.area_used    = area_r;

endmodule

/* hdl/srp_checker.sv */
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks on the shelf rectangle packer, bound to the top level.
// ----------------------------------------------------------------------------
module srp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic           placed,
  input srp_pkg::dim_t  place_left,
  input srp_pkg::dim_t  place_top,
  input srp_pkg::dim_t  place_width,
  input srp_pkg::dim_t  place_height,
  input srp_pkg::area_t area_used
);

  // The block never takes a new word while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request accepted while a result is pending");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready did not drop after an accepted request");

  // A failed placement reports zeros for everything but the area.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !placed) |->
      (place_left == '0 && place_top == '0 && place_width == '0 &&
       place_height == '0))
    else $error("failed placement with nonzero fields");

  // A stalled result holds its area.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(area_used)))
    else $error("stalled result changed");

endmodule

bind shelf_rectangle_packer srp_checker u_srp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_port.valid),
  .in_ready     (in_port.ready),
  .out_valid    (out_port.valid),
  .out_ready    (out_port.ready),
  .placed       (out_port.placed),
  .place_left   (out_port.place_left),
  .place_top    (out_port.place_top),
  .place_width  (out_port.place_width),
  .place_height (out_port.place_height),
  .area_used    (out_port.area_used)
);
